// ===== src/assert_macros.svh =====
// Assertion macros shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, held off while in reset.
`define ASSERT_IMPLIES(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Condition that must never be true at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/hrmp_pkg.sv =====
// Shared types and constants for the heart rate measurement parser.
package hrmp_pkg;

    localparam int MAX_PACKET_BYTES_DEFAULT = 512;
    localparam int QUEUE_DEPTH = 2;

    // Result kinds as seen on the output port.
    localparam logic [1:0] KIND_HEART   = 2'd0;
    localparam logic [1:0] KIND_RR      = 2'd1;
    localparam logic [1:0] KIND_BATTERY = 2'd2;

    // Flag byte masks of a heart rate payload.
    localparam logic [7:0] FLAG_FORMAT16 = 8'h01;
    localparam logic [7:0] FLAG_ENERGY   = 8'h08;
    localparam logic [7:0] FLAG_RR       = 8'h10;

    // An RR count of 1/1024 s times 125 gives 1/128 ms.
    localparam logic [6:0] RR_SCALE = 7'd125;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        changed;
    } cmd_t;

endpackage

// ===== src/heart_rate_measurement_parser.sv =====
// Top level of the heart rate measurement parser.
//
//  Channel  Direction  Handshake              Payload
//  input    in         in_valid / in_ready    char_kind, payload_byte, last_byte
//  output   out        out_valid / out_ready  result_kind, heart_rate, rr_raw,
//                                             rr_time_128ths_ms, battery_percent,
//                                             battery_changed
//
// One byte is taken per cycle while in_ready is high; a result passes
// through a queue entry, then the output register that holds the RR multiply.
// in_ready falls only when the two-entry command queue is full, which
// happens only while the consumer holds out_ready low.
// Reset clears the packet position, flags and stored battery level at once.
module heart_rate_measurement_parser #(
    parameter int MAX_PACKET_BYTES = hrmp_pkg::MAX_PACKET_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        char_kind,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [15:0] heart_rate,
    output logic [15:0] rr_raw,
    output logic [22:0] rr_time_128ths_ms,
    output logic [7:0]  battery_percent,
    output logic        battery_changed
);
    import hrmp_pkg::*;

    logic push;
    logic pop;
    logic queue_full;
    logic queue_not_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    hrmp_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_kind    (char_kind),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .queue_full   (queue_full),
        .push         (push),
        .cmd          (push_cmd)
    );

    hrmp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    hrmp_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_avail         (queue_not_empty),
        .cmd               (head_cmd),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .heart_rate        (heart_rate),
        .rr_raw            (rr_raw),
        .rr_time_128ths_ms (rr_time_128ths_ms),
        .battery_percent   (battery_percent),
        .battery_changed   (battery_changed)
    );

endmodule

// ===== src/hrmp_front.sv =====
// Byte parser: tracks packet position and flags, emits one command per result.
module hrmp_front #(
    parameter int MAX_PACKET_BYTES = hrmp_pkg::MAX_PACKET_BYTES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          char_kind,
    input  logic [7:0]    payload_byte,
    input  logic          last_byte,
    input  logic          queue_full,
    output logic          push,
    output hrmp_pkg::cmd_t cmd
);
    import hrmp_pkg::*;

    localparam int PosWidth = $clog2(MAX_PACKET_BYTES + 1);

    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [7:0]          flags_reg, flags_next;
    logic [7:0]          held_reg, held_next;
    logic [7:0]          battery_reg, battery_next;
    logic                rr_phase_reg, rr_phase_next;
    logic                pkt_battery_reg, pkt_battery_next;

    logic       accept;
    logic       fmt16;
    logic       rr_on;
    logic [2:0] rr_start;
    logic       pos_zero;
    logic       battery_now;

    assign in_ready    = !queue_full;
    assign accept      = in_valid && in_ready;
    assign fmt16       = (flags_reg & FLAG_FORMAT16) != 8'h00;
    assign rr_on       = (flags_reg & FLAG_RR) != 8'h00;
    assign rr_start    = (fmt16 ? 3'd3 : 3'd2) + (((flags_reg & FLAG_ENERGY) != 8'h00) ? 3'd2 : 3'd0);
    assign pos_zero    = pos_reg == '0;
    assign battery_now = pos_zero ? char_kind : pkt_battery_reg;

    always_comb
    begin
        pos_next         = pos_reg;
        flags_next       = flags_reg;
        held_next        = held_reg;
        battery_next     = battery_reg;
        rr_phase_next    = rr_phase_reg;
        pkt_battery_next = pkt_battery_reg;
        push             = 1'b0;
        cmd              = '0;
        if (accept)
        begin
            if (pos_reg < PosWidth'(MAX_PACKET_BYTES))
            begin
                if (pos_zero)
                begin
                    pkt_battery_next = char_kind;
                    rr_phase_next    = 1'b0;
                end
                if (battery_now)
                begin
                    if (pos_zero)
                    begin
                        push         = 1'b1;
                        cmd.kind     = KIND_BATTERY;
                        cmd.value    = {8'h00, payload_byte};
                        cmd.changed  = payload_byte != battery_reg;
                        battery_next = payload_byte;
                    end
                end
                else if (pos_zero)
                begin
                    flags_next = payload_byte;
                end
                else if (pos_reg == PosWidth'(1))
                begin
                    if (fmt16 && !last_byte)
                    begin
                        held_next = payload_byte;
                    end
                    else
                    begin
                        push      = 1'b1;
                        cmd.kind  = KIND_HEART;
                        cmd.value = {8'h00, payload_byte};
                    end
                end
                else if (pos_reg == PosWidth'(2) && fmt16)
                begin
                    push      = 1'b1;
                    cmd.kind  = KIND_HEART;
                    cmd.value = {payload_byte, held_reg};
                end
                else if (rr_on && pos_reg >= PosWidth'(rr_start))
                begin
                    if (!rr_phase_reg)
                    begin
                        held_next     = payload_byte;
                        rr_phase_next = 1'b1;
                    end
                    else
                    begin
                        rr_phase_next = 1'b0;
                        push          = 1'b1;
                        cmd.kind      = KIND_RR;
                        cmd.value     = {payload_byte, held_reg};
                    end
                end
                pos_next = pos_reg + 1'b1;
            end
            if (last_byte)
            begin
                pos_next      = '0;
                rr_phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            flags_reg       <= '0;
            held_reg        <= '0;
            battery_reg     <= '0;
            rr_phase_reg    <= 1'b0;
            pkt_battery_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            flags_reg       <= flags_next;
            held_reg        <= held_next;
            battery_reg     <= battery_next;
            rr_phase_reg    <= rr_phase_next;
            pkt_battery_reg <= pkt_battery_next;
        end
    end

endmodule

// ===== src/hrmp_queue.sv =====
// Short command queue between the parser and the result stage.
`include "assert_macros.svh"

module hrmp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hrmp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output hrmp_pkg::cmd_t head
);
    import hrmp_pkg::*;

    localparam int PtrWidth   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

    cmd_t                  entries_reg [QUEUE_DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0] count_reg, count_next;

    assign full      = count_reg == CountWidth'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entries_reg[rd_ptr_reg];

    function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] p);
        return (p == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_NEVER(a_no_overflow, push && full && !pop, "command pushed into a full queue")
    `ASSERT_NEVER(a_no_underflow, pop && !not_empty, "command popped from an empty queue")
    `ASSERT_NEVER(a_count_range, count_reg > CountWidth'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== src/hrmp_back.sv =====
// Result stage: scales RR intervals and holds the result for the consumer.
`include "assert_macros.svh"

module hrmp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_avail,
    input  hrmp_pkg::cmd_t cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     result_kind,
    output logic [15:0]    heart_rate,
    output logic [15:0]    rr_raw,
    output logic [22:0]    rr_time_128ths_ms,
    output logic [7:0]     battery_percent,
    output logic           battery_changed
);
    import hrmp_pkg::*;

    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg;
    logic [15:0] heart_reg;
    logic [15:0] rr_raw_reg;
    logic [22:0] rr_time_reg;
    logic [7:0]  battery_reg;
    logic        changed_reg;
    logic [22:0] product;

    assign pop        = cmd_avail && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign product    = 23'(cmd.value) * 23'(RR_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Fields that do not belong to the result kind read as zero.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg    <= cmd.kind;
            heart_reg   <= (cmd.kind == KIND_HEART) ? cmd.value : 16'h0000;
            rr_raw_reg  <= (cmd.kind == KIND_RR) ? cmd.value : 16'h0000;
            rr_time_reg <= (cmd.kind == KIND_RR) ? product : 23'h000000;
            battery_reg <= (cmd.kind == KIND_BATTERY) ? cmd.value[7:0] : 8'h00;
            changed_reg <= (cmd.kind == KIND_BATTERY) && cmd.changed;
        end
    end

    assign out_valid         = valid_reg;
    assign result_kind       = kind_reg;
    assign heart_rate        = heart_reg;
    assign rr_raw            = rr_raw_reg;
    assign rr_time_128ths_ms = rr_time_reg;
    assign battery_percent   = battery_reg;
    assign battery_changed   = changed_reg;

    `ASSERT_IMPLIES(a_rr_scaled, valid_reg && kind_reg == KIND_RR, rr_time_reg == 23'(rr_raw_reg) * 23'(RR_SCALE), "RR time does not match raw interval")
    `ASSERT_IMPLIES(a_kind_legal, valid_reg, kind_reg != 2'd3, "illegal result kind")
    `ASSERT_IMPLIES(a_held_result, valid_reg && !out_ready, !pop, "pending result overwritten")

endmodule
